/* sv/nfs_pkg.sv */
// ----------------------------------------------------------------------------
// nfs_pkg
// Shared widths, types and helpers for the 2-3-5 smooth number search.
// ----------------------------------------------------------------------------
package nfs_pkg;

  localparam int VALUE_BITS = 31;
  localparam int IDX_W      = 11;
  localparam int OUT_W      = 31;
  localparam int CNT_W      = IDX_W + 1;
  localparam int BL_W       = $clog2(VALUE_BITS + 1);
  localparam int SRCH_W     = VALUE_BITS + 1;
  localparam int PROD_W     = VALUE_BITS + 3;

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [OUT_W-1:0]      out_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [BL_W-1:0]       bl_t;
  typedef logic [SRCH_W-1:0]     srch_t;
  typedef logic [PROD_W-1:0]     prod_t;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_ROUND,
    SRCH_WAIT
  } srch_state_e;

  typedef enum logic [1:0] {
    CNT_IDLE,
    CNT_PAIR,
    CNT_NEXT5
  } cnt_state_e;

  typedef struct packed {
    logic start;
  } cnt_ctl_t;

  typedef struct packed {
    logic done;
    logic reached;
  } cnt_sts_t;

  // bit length: index of the highest set bit plus one
  function automatic bl_t bit_len(val_t v);
    bl_t bl;
    bl = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (v[i]) begin
        bl = bl_t'(i + 1);
      end
    end
    return bl;
  endfunction

endpackage

/* sv/nth_five_smooth_number_top.sv */
// ----------------------------------------------------------------------------
// nth_five_smooth_number_top
// Finds the n-th number whose only prime factors are 2, 3 and 5.
// ----------------------------------------------------------------------------
// Usage:
//   Drive nth_index_i and raise start while busy is low; the beat is taken
//   at that edge and busy rises on the next cycle. An index of zero gives 1.
//   The block binary-searches 1 .. 2^31-1 (31 rounds). Each round counts
//   smooth numbers at or below the midpoint, one 5^a*3^b product per cycle
//   except while stepping to the next power of 5 or in round control; the
//   count stops early once it reaches the index. Search time depends on the
//   index, set by the product walk of the counting unit.
//   The result beat is shown for exactly one cycle with done_o high:
//   smooth_value_o and found_o. If fewer than n smooth numbers lie in the
//   range, found_o is 0 and smooth_value_o is 0. The receiver cannot stall;
//   busy is already low in the done_o cycle, so a new start may be taken
//   there. Reset returns both sequencers to idle and drops done_o.
// ----------------------------------------------------------------------------
module nth_five_smooth_number_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [10:0]            nth_index_i,
  output logic                   done_o,
  output logic [30:0]            smooth_value_o,
  output logic                   found_o
);

  nfs_pkg::srch_state_e state_q, state_d;
  nfs_pkg::srch_t       lo_q, lo_d;
  nfs_pkg::srch_t       hi_q, hi_d;
  nfs_pkg::val_t        mid_q, mid_d;
  nfs_pkg::val_t        ans_q, ans_d;
  logic                 hit_q, hit_d;
  nfs_pkg::idx_t        n_q, n_d;
  logic                 done_q, done_d;
  nfs_pkg::out_t        value_q, value_d;
  logic                 found_q, found_d;

  nfs_pkg::cnt_ctl_t    cnt_ctl;
  nfs_pkg::cnt_sts_t    cnt_sts;
  nfs_pkg::srch_t       mid_calc;

  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);

  nfs_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cnt_ctl),
    .value_i (mid_d),
    .nth_i   (n_q),
    .sts_o   (cnt_sts)
  );

  always_comb begin
    state_d       = state_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    ans_d         = ans_q;
    hit_d         = hit_q;
    n_d           = n_q;
    done_d        = 1'b0;
    value_d       = value_q;
    found_d       = found_q;
    cnt_ctl.start = 1'b0;
    case (state_q)
      nfs_pkg::SRCH_IDLE: begin
        if (start) begin
          lo_d    = nfs_pkg::srch_t'(1);
          hi_d    = nfs_pkg::srch_t'({nfs_pkg::VALUE_BITS{1'b1}});
          ans_d   = '0;
          hit_d   = 1'b0;
          n_d     = nth_index_i;
          state_d = nfs_pkg::SRCH_ROUND;
        end
      end
      nfs_pkg::SRCH_ROUND: begin
        if (lo_q <= hi_q) begin
          mid_d         = nfs_pkg::val_t'(mid_calc);
          cnt_ctl.start = 1'b1;
          state_d       = nfs_pkg::SRCH_WAIT;
        end else begin
          done_d  = 1'b1;
          value_d = hit_q ? nfs_pkg::out_t'(ans_q) : '0;
          found_d = hit_q;
          state_d = nfs_pkg::SRCH_IDLE;
        end
      end
      nfs_pkg::SRCH_WAIT: begin
        if (cnt_sts.done) begin
          if (cnt_sts.reached) begin
            ans_d = mid_q;
            hit_d = 1'b1;
            hi_d  = nfs_pkg::srch_t'(mid_q) - nfs_pkg::srch_t'(1);
          end else begin
            lo_d = nfs_pkg::srch_t'(mid_q) + nfs_pkg::srch_t'(1);
          end
          state_d = nfs_pkg::SRCH_ROUND;
        end
      end
      default: begin
        state_d = nfs_pkg::SRCH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfs_pkg::SRCH_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    ans_q   <= ans_d;
    hit_q   <= hit_d;
    n_q     <= n_d;
    value_q <= value_d;
    found_q <= found_d;
  end

  assign busy           = (state_q != nfs_pkg::SRCH_IDLE);
  assign done_o         = done_q;
  assign smooth_value_o = value_q;
  assign found_o        = found_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while search active");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> smooth_value_o == '0)
    else $error("miss carries nonzero value");

  a_wait_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nfs_pkg::SRCH_WAIT |-> lo_q <= hi_q && mid_q != '0)
    else $error("round started on empty interval");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted beat did not start a search");

endmodule

/* sv/nfs_count.sv */
// ----------------------------------------------------------------------------
// nfs_count
// Counts smooth numbers at or below a value, one (5^a * 3^b) product per
// cycle except on steps to a new power of 5; stops early at the wanted index.
// ----------------------------------------------------------------------------
module nfs_count (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nfs_pkg::cnt_ctl_t ctl_i,
  input  nfs_pkg::val_t     value_i,
  input  nfs_pkg::idx_t     nth_i,
  output nfs_pkg::cnt_sts_t sts_o
);

  nfs_pkg::cnt_state_e state_q, state_d;
  nfs_pkg::val_t       v_q, v_d;
  nfs_pkg::val_t       p_q, p_d;
  nfs_pkg::val_t       p5_q, p5_d;
  nfs_pkg::bl_t        blv_q, blv_d;
  nfs_pkg::cnt_t       total_q, total_d;
  nfs_pkg::idx_t       n_q, n_d;

  nfs_pkg::bl_t        shift_amt;
  nfs_pkg::val_t       shifted;
  nfs_pkg::bl_t        contrib;
  nfs_pkg::cnt_t       total_sum;
  nfs_pkg::prod_t      triple;
  nfs_pkg::prod_t      quint;
  nfs_pkg::prod_t      v_ext;

  // powers of two that fit: v >= p << k for k = 0 .. contrib-1
  assign shift_amt = blv_q - nfs_pkg::bit_len(p_q);
  assign shifted   = p_q << shift_amt;
  assign contrib   = shift_amt + nfs_pkg::bl_t'(shifted <= v_q);
  assign total_sum = total_q + nfs_pkg::cnt_t'(contrib);
  assign v_ext     = nfs_pkg::prod_t'(v_q);
  assign triple    = nfs_pkg::prod_t'(p_q) + (nfs_pkg::prod_t'(p_q) << 1);
  assign quint     = nfs_pkg::prod_t'(p5_q) + (nfs_pkg::prod_t'(p5_q) << 2);

  always_comb begin
    state_d       = state_q;
    v_d           = v_q;
    p_d           = p_q;
    p5_d          = p5_q;
    blv_d         = blv_q;
    total_d       = total_q;
    n_d           = n_q;
    sts_o.done    = 1'b0;
    sts_o.reached = 1'b0;
    case (state_q)
      nfs_pkg::CNT_IDLE: begin
        if (ctl_i.start) begin
          v_d     = value_i;
          blv_d   = nfs_pkg::bit_len(value_i);
          p_d     = nfs_pkg::val_t'(1);
          p5_d    = nfs_pkg::val_t'(1);
          total_d = '0;
          n_d     = nth_i;
          state_d = nfs_pkg::CNT_PAIR;
        end
      end
      nfs_pkg::CNT_PAIR: begin
        total_d = total_sum;
        if (total_sum >= nfs_pkg::cnt_t'(n_q)) begin
          sts_o.done    = 1'b1;
          sts_o.reached = 1'b1;
          state_d       = nfs_pkg::CNT_IDLE;
        end else if (triple <= v_ext) begin
          p_d = nfs_pkg::val_t'(triple);
        end else begin
          state_d = nfs_pkg::CNT_NEXT5;
        end
      end
      nfs_pkg::CNT_NEXT5: begin
        if (quint <= v_ext) begin
          p5_d    = nfs_pkg::val_t'(quint);
          p_d     = nfs_pkg::val_t'(quint);
          state_d = nfs_pkg::CNT_PAIR;
        end else begin
          sts_o.done = 1'b1;
          state_d    = nfs_pkg::CNT_IDLE;
        end
      end
      default: begin
        state_d = nfs_pkg::CNT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfs_pkg::CNT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    p_q     <= p_d;
    p5_q    <= p5_d;
    blv_q   <= blv_d;
    total_q <= total_d;
    n_q     <= n_d;
  end

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == nfs_pkg::CNT_IDLE)
    else $error("count start while busy");

  a_product_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nfs_pkg::CNT_PAIR |-> p_q <= v_q && p_q != '0)
    else $error("product outside range");

  a_total_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nfs_pkg::CNT_NEXT5 |-> total_q < nfs_pkg::cnt_t'(n_q))
    else $error("count passed index without stopping");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |=> state_q == nfs_pkg::CNT_IDLE)
    else $error("count did not return to idle");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the 2-3-5 smooth number search block. An initial block queues
// directed indices (zero, single bits, all ones, both sides of the last index
// that still fits in range) and then random ones. A negedge driver presents
// them with random idle bursts. A posedge monitor computes the expected value
// and found flag for each accepted beat with its own binary search over a
// smooth number count, and compares them with every done_o beat in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    nfs_pkg::out_t value;
    logic          found;
  } smooth_answer_t;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          start          = 1'b0;
  nfs_pkg::idx_t nth_index_i    = '0;
  logic          busy;
  logic          done_o;
  nfs_pkg::out_t smooth_value_o;
  logic          found_o;

  nfs_pkg::idx_t  index_queue[$];
  smooth_answer_t expected_answers[$];
  logic           beat_taken     = 1'b0;
  int unsigned    idle_left      = 0;
  int unsigned    beat_count     = 0;
  int unsigned    item_total     = 0;
  int unsigned    mismatch_count = 0;

  nth_five_smooth_number_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .nth_index_i    (nth_index_i),
    .done_o         (done_o),
    .smooth_value_o (smooth_value_o),
    .found_o        (found_o)
  );

  always #5 clk_i = ~clk_i;

  // how many 2-3-5 smooth numbers lie in 1..v (v >= 1)
  function automatic longint unsigned smooth_tally(longint unsigned v);
    longint unsigned total, p5, p3, limit, q;
    total = 0;
    p5 = 1;
    forever begin
      limit = v / p5;
      p3 = 1;
      forever begin
        q = limit / p3;
        while (q != 0) begin
          total++;
          q >>= 1;
        end
        if (p3 > limit / 3) break;
        p3 *= 3;
      end
      if (p5 > v / 5) break;
      p5 *= 5;
    end
    return total;
  endfunction

  // smallest v whose tally reaches n
  function automatic smooth_answer_t nth_smooth(nfs_pkg::idx_t n);
    longint unsigned lo, hi, mid;
    smooth_answer_t ans;
    lo  = 1;
    hi  = (64'd1 << nfs_pkg::VALUE_BITS) - 1;
    ans = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (smooth_tally(mid) < longint'(n)) begin
        lo = mid + 1;
      end else begin
        ans.value = nfs_pkg::out_t'(mid);
        ans.found = 1'b1;
        hi = mid - 1;
      end
    end
    return ans;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (idle_left != 0) begin
        start <= 1'b0;
        if (!busy) idle_left <= idle_left - 1;
      end else if (index_queue.size() != 0) begin
        nth_index_i <= index_queue.pop_front();
        start <= 1'b1;
        if (index_queue.size() > 15 && $urandom_range(0, 2) == 0) begin
          idle_left <= $urandom_range(1, 3);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    smooth_answer_t oldest;
    if (!rst_ni) begin
      beat_taken <= 1'b0;
    end else begin
      if (done_o) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with nothing expected: smooth_value %0d found %0b",
                 smooth_value_o, found_o);
          mismatch_count++;
        end else begin
          oldest = expected_answers.pop_front();
          if (smooth_value_o !== oldest.value) begin
            $error("smooth_value: expected %0d, got %0d", oldest.value, smooth_value_o);
            mismatch_count++;
          end
          if (found_o !== oldest.found) begin
            $error("found: expected %0b, got %0b", oldest.found, found_o);
            mismatch_count++;
          end
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy) begin
        expected_answers.push_back(nth_smooth(nth_index_i));
        beat_count++;
      end
    end
  end

  initial begin
    int unsigned in_range;
    in_range = int'(smooth_tally((64'd1 << nfs_pkg::VALUE_BITS) - 1));

    // directed
    index_queue.push_back(nfs_pkg::idx_t'(0));
    index_queue.push_back(nfs_pkg::idx_t'(1));
    index_queue.push_back(nfs_pkg::idx_t'(2));
    index_queue.push_back(nfs_pkg::idx_t'(3));
    index_queue.push_back(nfs_pkg::idx_t'(7));
    index_queue.push_back(nfs_pkg::idx_t'(10));
    index_queue.push_back(nfs_pkg::idx_t'(16));
    index_queue.push_back(nfs_pkg::idx_t'(341));
    index_queue.push_back(nfs_pkg::idx_t'(682));
    index_queue.push_back(nfs_pkg::idx_t'(1023));
    index_queue.push_back(nfs_pkg::idx_t'(1024));
    index_queue.push_back(nfs_pkg::idx_t'(1365));
    index_queue.push_back(nfs_pkg::idx_t'(1690));
    index_queue.push_back(nfs_pkg::idx_t'(in_range - 1));
    index_queue.push_back(nfs_pkg::idx_t'(in_range));
    if (in_range < 2047) index_queue.push_back(nfs_pkg::idx_t'(in_range + 1));
    index_queue.push_back(nfs_pkg::idx_t'(2047));
    index_queue.push_back(nfs_pkg::idx_t'(0));

    // random: mostly indices that resolve, some past the range
    repeat (102) begin
      case ($urandom_range(0, 9))
        0, 1:    index_queue.push_back(nfs_pkg::idx_t'($urandom_range(in_range + 1, 2047)));
        2:       index_queue.push_back(nfs_pkg::idx_t'($urandom_range(0, 2047)));
        default: index_queue.push_back(nfs_pkg::idx_t'($urandom_range(0, in_range)));
      endcase
    end
    item_total = index_queue.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (beat_count != item_total || expected_answers.size() != 0);
    repeat (6000) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule

/* filelist.f */
sv/nfs_pkg.sv
sv/nfs_count.sv
sv/nth_five_smooth_number_top.sv
tb/sv/testbench.sv
